// ----- hdl/pppoe_discovery_client_unit_macros.svh -----
// Assertion macros for the PPPoE discovery client.
// Included by the checker module; no other dependencies.
`ifndef PPPOE_DISCOVERY_CLIENT_UNIT_MACROS_SVH
`define PPPOE_DISCOVERY_CLIENT_UNIT_MACROS_SVH
`define PDC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("%m failed");
`define PDC_ASSERT_IMP(lbl, a, b) \
  `PDC_ASSERT(lbl, (a) |-> (b))
`endif

// ----- hdl/pdc_pkg.sv -----
// Package for the PPPoE discovery client: types, codes and constants.
// No dependencies.
package pdc_pkg;
  localparam int unsigned MaxFrameDefault = 1514;
  localparam int unsigned FrameBytes = 30;
  localparam int unsigned HdrEnd = 20;
  localparam logic [7:0] CodePadi = 8'h09;
  localparam logic [7:0] CodePadr = 8'h19;
  localparam logic [7:0] CodePads = 8'h65;
  localparam logic [15:0] HostUniqType = 16'h0103;
  localparam logic [16:0] TagStartMax = 17'h1FFFF;
  localparam logic [47:0] BcastMac = 48'hFFFF_FFFF_FFFF;
  localparam logic [0:0] RegOwnMac = 1'b0;
  localparam logic [0:0] RegHostTag = 1'b1;

  typedef enum logic [1:0] {PhIdle, PhOffer, PhConfirm, PhEst} phase_e;
  typedef enum logic [1:0] {VUndec, VAccept, VReject, VOver} verdict_e;
  typedef enum logic [1:0] {JobPadi, JobPadr, JobReport} job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [47:0] mac;
    logic [15:0] session;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        run_last;
    logic [15:0] session_number;
    logic [47:0] server_mac;
  } result_t;
endpackage

// ----- hdl/pdc_parser.sv -----
// Front part: accepts items, parses received frames, posts jobs.
// Depends on pdc_pkg.
module pdc_parser #(
  parameter int unsigned MaxFrame = pdc_pkg::MaxFrameDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [47:0]    own_mac_i,
  input  logic [15:0]    host_tag_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           opcode_i,
  input  logic [7:0]     rx_byte_i,
  input  logic           rx_end_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output pdc_pkg::job_t  job_o
);
  import pdc_pkg::*;
  localparam int unsigned PosW = $clog2(MaxFrame + 1);

  phase_e      phase_q, phase_d;
  verdict_e    verdict_q, verdict_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic        dm_q, dm_d;
  logic [47:0] src_q, src_d, peer_q, peer_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] sess_q, sess_d, plen_q, plen_d;
  logic [16:0] tstart_q, tstart_d;
  logic [15:0] ttype_q, ttype_d, tlen_q, tlen_d, tval_q, tval_d;
  logic        acc;
  logic [16:0] p, d;
  logic [17:0] nx;
  logic [15:0] lenw, valw;
  logic [7:0]  mb;
  logic        good;

  assign in_ready_o = job_ready_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q; verdict_d = verdict_q; pos_d = pos_q; dm_d = dm_q;
    src_d = src_q; peer_d = peer_q; code_d = code_q; sess_d = sess_q;
    plen_d = plen_q; tstart_d = tstart_q; ttype_d = ttype_q; tlen_d = tlen_q;
    tval_d = tval_q;
    job_valid_o = 1'b0;
    job_o = '{kind: JobPadi, mac: BcastMac, session: 16'd0};
    p = 17'(pos_q) - 17'(HdrEnd);
    d = p - tstart_q;
    lenw = {tlen_q[7:0], rx_byte_i};
    valw = {tval_q[7:0], rx_byte_i};
    nx = 18'(tstart_q) + 18'd4 + 18'(lenw);
    case (pos_q[2:0])
      3'd0: mb = own_mac_i[47:40];
      3'd1: mb = own_mac_i[39:32];
      3'd2: mb = own_mac_i[31:24];
      3'd3: mb = own_mac_i[23:16];
      3'd4: mb = own_mac_i[15:8];
      default: mb = own_mac_i[7:0];
    endcase
    good = 1'b0;
    if (acc) begin
      if (!opcode_i) begin
        phase_d = PhOffer;
        job_valid_o = 1'b1;
        pos_d = '0; dm_d = 1'b0; src_d = '0; code_d = '0; sess_d = '0;
        plen_d = '0; tstart_d = '0; ttype_d = '0; tlen_d = '0; tval_d = '0;
        verdict_d = VUndec;
      end else begin
        if (32'(pos_q) >= MaxFrame) begin
          verdict_d = VOver;
        end else begin
          pos_d = pos_q + 1'b1;
          if (32'(pos_q) < 6) begin
            dm_d = (pos_q == '0 || dm_q) && rx_byte_i == mb;
          end else if (32'(pos_q) < 12) begin
            src_d = {src_q[39:0], rx_byte_i};
          end else if (32'(pos_q) == 15) begin
            code_d = rx_byte_i;
          end else if (32'(pos_q) == 16 || 32'(pos_q) == 17) begin
            sess_d = {sess_q[7:0], rx_byte_i};
          end else if (32'(pos_q) == 18 || 32'(pos_q) == 19) begin
            plen_d = {plen_q[7:0], rx_byte_i};
          end else if (32'(pos_q) >= HdrEnd && verdict_q == VUndec &&
                       p >= tstart_q && tstart_q < 17'(plen_q)) begin
            case (d)
              17'd0: ttype_d = {8'd0, rx_byte_i};
              17'd1: ttype_d = {ttype_q[7:0], rx_byte_i};
              17'd2: tlen_d = {8'd0, rx_byte_i};
              17'd3: begin
                tlen_d = lenw;
                if (ttype_q == HostUniqType) begin
                  if (lenw != 16'd2 || 18'(tstart_q) + 18'd6 > 18'(plen_q)) begin
                    verdict_d = VReject;
                  end
                end else begin
                  tstart_d = (nx > 18'(TagStartMax)) ? TagStartMax : nx[16:0];
                end
              end
              17'd4: tval_d = {8'd0, rx_byte_i};
              17'd5: begin
                tval_d = valw;
                verdict_d = (valw == host_tag_i) ? VAccept : VReject;
              end
              default: ;
            endcase
          end
        end
        if (rx_end_i) begin
          good = 32'(pos_d) >= HdrEnd && verdict_d != VOver;
          case (phase_q)
            PhOffer: begin
              if (good && dm_d && verdict_d == VAccept) begin
                peer_d = src_d; phase_d = PhConfirm; job_valid_o = 1'b1;
                job_o = '{kind: JobPadr, mac: src_d, session: 16'd0};
              end
            end
            PhConfirm: begin
              if (good && code_d == CodePads) begin
                phase_d = PhEst; job_valid_o = 1'b1;
                job_o = '{kind: JobReport, mac: peer_q, session: sess_d};
              end
            end
            default: ;
          endcase
          pos_d = '0; dm_d = 1'b0; src_d = '0; code_d = '0; sess_d = '0;
          plen_d = '0; tstart_d = '0; ttype_d = '0; tlen_d = '0; tval_d = '0;
          verdict_d = VUndec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; verdict_q <= VUndec; pos_q <= '0; dm_q <= 1'b0;
      src_q <= '0; peer_q <= '0; code_q <= '0; sess_q <= '0; plen_q <= '0;
      tstart_q <= '0; ttype_q <= '0; tlen_q <= '0; tval_q <= '0;
    end else begin
      phase_q <= phase_d; verdict_q <= verdict_d; pos_q <= pos_d; dm_q <= dm_d;
      src_q <= src_d; peer_q <= peer_d; code_q <= code_d; sess_q <= sess_d;
      plen_q <= plen_d; tstart_q <= tstart_d; ttype_q <= ttype_d;
      tlen_q <= tlen_d; tval_q <= tval_d;
    end
  end
endmodule

// ----- hdl/pdc_job_fifo.sv -----
// Short job queue between the parser and the frame emitter.
// Depends on pdc_pkg.
module pdc_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  pdc_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output pdc_pkg::job_t rd_data_o
);
  import pdc_pkg::*;
  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ----- hdl/pdc_emitter.sv -----
// Back part: turns jobs into frame bytes or a report, with an output register.
// Depends on pdc_pkg.
module pdc_emitter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [47:0]      own_mac_i,
  input  logic [15:0]      host_tag_i,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  pdc_pkg::job_t    job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdc_pkg::result_t out_o
);
  import pdc_pkg::*;
  logic [4:0] idx_q, idx_d;
  logic       ov_q;
  result_t    res_q, res_d;
  logic       load, last;
  logic [7:0] b;

  assign load = job_valid_i && (!ov_q || out_ready_i);
  assign last = job_i.kind == JobReport || idx_q == 5'(FrameBytes - 1);
  assign job_ready_o = load && last;
  assign out_valid_o = ov_q;
  assign out_o = res_q;

  always_comb begin
    b = 8'h00;
    if (idx_q < 5'd6) b = job_i.mac[8*(5-idx_q) +: 8];
    else if (idx_q < 5'd12) b = own_mac_i[8*(11-idx_q) +: 8];
    else begin
      case (idx_q)
        5'd12: b = 8'h88;
        5'd13: b = 8'h63;
        5'd14: b = 8'h11;
        5'd15: b = (job_i.kind == JobPadr) ? CodePadr : CodePadi;
        5'd19: b = 8'h0A;
        5'd20, 5'd21, 5'd24: b = 8'h01;
        5'd25: b = 8'h03;
        5'd27: b = 8'h02;
        5'd28: b = host_tag_i[15:8];
        5'd29: b = host_tag_i[7:0];
        default: b = 8'h00;
      endcase
    end
    if (job_i.kind == JobReport) begin
      res_d = '{kind: 1'b1, tx_byte: 8'd0, run_last: 1'b1,
                session_number: job_i.session, server_mac: job_i.mac};
    end else begin
      res_d = '{kind: 1'b0, tx_byte: b, run_last: last,
                session_number: 16'd0, server_mac: 48'd0};
    end
    idx_d = idx_q;
    if (load) idx_d = last ? 5'd0 : idx_q + 5'd1;
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; ov_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end
endmodule

// ----- hdl/pppoe_discovery_client_unit.sv -----
// Top level of the PPPoE discovery client.
// Depends on pdc_pkg, pdc_parser, pdc_job_fifo and pdc_emitter.
//
// Takes one item per cycle while the job queue has room: a start item (tuser 0) or one
// received frame byte (tuser 1, tlast on the final byte). A start emits a 30-byte PADI; an
// accepted offer emits a 30-byte PADR; a confirm emits one session report.
// Received bytes are parsed at one per cycle; the input stalls only while the
// two-entry job queue is full, because the emitter sends one byte per cycle while
// the output is ready, so a frame job occupies the output until all 30 bytes are out.
module pppoe_discovery_client_unit #(
  parameter int unsigned MaxFrame = pdc_pkg::MaxFrameDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tlast,   // rx_end
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // tx_byte, session_number, server_mac
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // kind
);
  import pdc_pkg::*;
  logic [47:0] own_mac_q;
  logic [15:0] host_tag_q;
  logic jv, jr, qv, qr;
  job_t jd, qd;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0; host_tag_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegOwnMac) own_mac_q <= cfg_data_i;
      else if (cfg_index_i == RegHostTag) host_tag_q <= cfg_data_i[15:0];
    end
  end

  pdc_parser #(.MaxFrame(MaxFrame)) u_parser (
    .clk_i, .rst_ni, .own_mac_i(own_mac_q), .host_tag_i(host_tag_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .rx_byte_i(s_axis_tdata), .rx_end_i(s_axis_tlast),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(jd));

  pdc_job_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(jv), .wr_ready_o(jr), .wr_data_i(jd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd));

  pdc_emitter u_emitter (
    .clk_i, .rst_ni, .own_mac_i(own_mac_q), .host_tag_i(host_tag_q),
    .job_valid_i(qv), .job_ready_o(qr), .job_i(qd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res));

  assign m_axis_tdata = {res.server_mac, res.session_number, res.tx_byte};
  assign m_axis_tlast = res.run_last;
  assign m_axis_tuser = res.kind;
endmodule

// ----- hdl/pdc_checker.sv -----
// Port-level checker for the PPPoE discovery client, bound to the top level.
// Depends on pppoe_discovery_client_unit_macros.svh.
`include "pppoe_discovery_client_unit_macros.svh"
module pdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  `PDC_ASSERT_IMP(a_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid)
  `PDC_ASSERT_IMP(a_report_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `PDC_ASSERT_IMP(a_report_zero, m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata[7:0] == 8'd0)
  `PDC_ASSERT_IMP(a_tx_clean, m_axis_tvalid && !m_axis_tuser,
                  m_axis_tdata[71:8] == 64'd0)
endmodule

bind pppoe_discovery_client_unit pdc_checker u_pdc_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
  .m_axis_tlast, .m_axis_tuser);

// ----- verif/tb_top.sv -----
// Self-checking bench for pppoe_discovery_client_unit: drives start items and
// received frame bytes, predicts PADI/PADR frames and session reports.
// Depends on pdc_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
  import pdc_pkg::*;

  localparam int unsigned TbMaxFrame = 64;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic       rx_end;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [47:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  pppoe_discovery_client_unit #(.MaxFrame(TbMaxFrame)) i_dut (.*);

  // Predictor state.
  logic [47:0] own_mac_q;
  logic [15:0] host_tag_q;
  phase_e      phase_q;
  int unsigned pos_q;
  logic        dest_ok_q;
  logic [47:0] src_cap_q;
  logic [7:0]  code_cap_q;
  logic [15:0] sess_cap_q;
  logic [15:0] plen_q;
  logic [16:0] tag_start_q;
  logic [15:0] tag_type_q;
  logic [15:0] tag_len_q;
  logic [15:0] tag_val_q;
  verdict_e    verdict_q;
  logic [47:0] peer_q;

  rx_item_t    pending_items[$];
  result_t     expected_results[$];
  int          failures = 0;
  int          accepted = 0;
  int          checked = 0;
  int          sessions = 0;
  int          frames_out = 0;
  longint      cycles = 0;

  function automatic void clear_parser();
    pos_q = 0; dest_ok_q = 0; src_cap_q = '0; code_cap_q = '0; sess_cap_q = '0;
    plen_q = '0; tag_start_q = '0; tag_type_q = '0; tag_len_q = '0;
    tag_val_q = '0; verdict_q = VUndec;
  endfunction

  function automatic void push_frame(logic [7:0] code, logic [47:0] dst);
    logic [7:0] f[30];
    result_t r;
    for (int i = 0; i < 6; i++) begin
      f[i] = dst[8*(5-i) +: 8];
      f[6+i] = own_mac_q[8*(5-i) +: 8];
    end
    f[12] = 8'h88; f[13] = 8'h63; f[14] = 8'h11; f[15] = code;
    f[16] = 8'h00; f[17] = 8'h00; f[18] = 8'h00; f[19] = 8'h0A;
    f[20] = 8'h01; f[21] = 8'h01; f[22] = 8'h00; f[23] = 8'h00;
    f[24] = 8'h01; f[25] = 8'h03; f[26] = 8'h00; f[27] = 8'h02;
    f[28] = host_tag_q[15:8]; f[29] = host_tag_q[7:0];
    for (int i = 0; i < 30; i++) begin
      r = '0;
      r.tx_byte = f[i];
      r.run_last = (i == 29);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void parse_byte(int unsigned pos, logic [7:0] b);
    int unsigned p, d, nx;
    if (pos < 6) begin
      dest_ok_q = ((pos == 0) ? 1'b1 : dest_ok_q) && (b == own_mac_q[8*(5-pos) +: 8]);
    end else if (pos < 12) begin
      src_cap_q = {src_cap_q[39:0], b};
    end else if (pos == 15) begin
      code_cap_q = b;
    end else if (pos == 16 || pos == 17) begin
      sess_cap_q = {sess_cap_q[7:0], b};
    end else if (pos == 18 || pos == 19) begin
      plen_q = {plen_q[7:0], b};
    end else if (pos >= HdrEnd && verdict_q == VUndec) begin
      p = pos - HdrEnd;
      if (p < tag_start_q || tag_start_q >= plen_q) return;
      d = p - tag_start_q;
      case (d)
        0: tag_type_q = {8'h00, b};
        1: tag_type_q = {tag_type_q[7:0], b};
        2: tag_len_q = {8'h00, b};
        3: begin
          tag_len_q = {tag_len_q[7:0], b};
          if (tag_type_q == HostUniqType) begin
            if (tag_len_q != 16'd2 || tag_start_q + 6 > plen_q) verdict_q = VReject;
          end else begin
            nx = tag_start_q + 4 + tag_len_q;
            tag_start_q = (nx > TagStartMax) ? TagStartMax : 17'(nx);
          end
        end
        4: tag_val_q = {8'h00, b};
        5: begin
          tag_val_q = {tag_val_q[7:0], b};
          verdict_q = (tag_val_q == host_tag_q) ? VAccept : VReject;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void predict_client(rx_item_t it);
    result_t r;
    bit good;
    if (!it.opcode) begin
      phase_q = PhOffer;
      clear_parser();
      push_frame(CodePadi, BcastMac);
      return;
    end
    if (pos_q >= TbMaxFrame) verdict_q = VOver;
    else begin
      parse_byte(pos_q, it.rx_byte);
      pos_q++;
    end
    if (it.rx_end) begin
      good = pos_q >= HdrEnd && verdict_q != VOver;
      if (phase_q == PhOffer) begin
        if (good && dest_ok_q && verdict_q == VAccept) begin
          peer_q = src_cap_q;
          phase_q = PhConfirm;
          push_frame(CodePadr, peer_q);
        end
      end else if (phase_q == PhConfirm) begin
        if (good && code_cap_q == CodePads) begin
          phase_q = PhEst;
          r = '0;
          r.kind = 1'b1;
          r.run_last = 1'b1;
          r.session_number = sess_cap_q;
          r.server_mac = peer_q;
          expected_results.push_back(r);
        end
      end
      clear_parser();
    end
  endfunction

  // Stimulus builders.
  task automatic add_item(logic op, logic [7:0] b, logic e);
    rx_item_t it;
    it.opcode = op; it.rx_byte = b; it.rx_end = e;
    pending_items.push_back(it);
  endtask

  task automatic add_frame(logic [7:0] bytes[$]);
    foreach (bytes[i]) add_item(1'b1, bytes[i], i == bytes.size() - 1);
  endtask

  // Builds a discovery frame; host_mode 0 good tag, 1 wrong value, 2 bad length,
  // 3 no tag, 4 tag past the PPPoE length.
  task automatic add_disc_frame(logic [47:0] dst, logic [47:0] src, logic [7:0] code,
                                logic [15:0] sess, int host_mode, int pre_tags);
    logic [7:0] q[$];
    logic [7:0] pl[$];
    int unsigned tl;
    for (int i = 0; i < pre_tags; i++) begin
      tl = $urandom_range(0, 3);
      pl.push_back(8'h01); pl.push_back(8'($urandom_range(0, 2)));
      pl.push_back(8'h00); pl.push_back(tl[7:0]);
      for (int k = 0; k < tl; k++) pl.push_back(8'($urandom));
    end
    if (host_mode != 3) begin
      pl.push_back(8'h01); pl.push_back(8'h03); pl.push_back(8'h00);
      pl.push_back(host_mode == 2 ? 8'h03 : 8'h02);
      pl.push_back(host_mode == 1 ? ~host_tag_q[15:8] : host_tag_q[15:8]);
      pl.push_back(host_tag_q[7:0]);
      if (host_mode == 2) pl.push_back(8'h00);
    end
    for (int i = 0; i < 6; i++) q.push_back(dst[8*(5-i) +: 8]);
    for (int i = 0; i < 6; i++) q.push_back(src[8*(5-i) +: 8]);
    q.push_back(8'h88); q.push_back(8'h63); q.push_back(8'h11); q.push_back(code);
    q.push_back(sess[15:8]); q.push_back(sess[7:0]);
    tl = (host_mode == 4) ? pl.size() - 1 : pl.size();
    q.push_back(tl[15:8]); q.push_back(tl[7:0]);
    foreach (pl[i]) q.push_back(pl[i]);
    add_frame(q);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegOwnMac) own_mac_q = val; else host_tag_q = val[15:0];
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Handshake seen at the rising edge, used by the driver at the next falling edge.
  logic s_axis_tready_s = 1'b0;

  // Driver: bursts with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready_s) begin
      // consumed at the previous rising edge
    end
    if (!s_axis_tvalid || s_axis_tready_s) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0 && rst_ni) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_items[0].opcode;
        s_axis_tdata <= pending_items[0].rx_byte;
        s_axis_tlast <= pending_items[0].rx_end;
        void'(pending_items.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= (cycles % 700 < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    s_axis_tready_s <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_client('{s_axis_tuser, s_axis_tdata, s_axis_tlast});
      accepted++;
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.tx_byte = m_axis_tdata[7:0];
      got.run_last = m_axis_tlast;
      got.session_number = m_axis_tdata[23:8];
      got.server_mac = m_axis_tdata[71:24];
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", got);
        failures++;
      end else begin
        exp_r = expected_results.pop_front();
        checked++;
        if (got.kind && got.run_last) sessions++;
        if (!got.kind && got.run_last) frames_out++;
        if (got.kind != exp_r.kind) begin
          $error("kind: expected %0h, got %0h", exp_r.kind, got.kind); failures++;
        end
        if (got.tx_byte != exp_r.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", exp_r.tx_byte, got.tx_byte);
          failures++;
        end
        if (got.run_last != exp_r.run_last) begin
          $error("run_last: expected %0h, got %0h", exp_r.run_last, got.run_last);
          failures++;
        end
        if (got.session_number != exp_r.session_number) begin
          $error("session_number: expected %0h, got %0h", exp_r.session_number,
                 got.session_number);
          failures++;
        end
        if (got.server_mac != exp_r.server_mac) begin
          $error("server_mac: expected %0h, got %0h", exp_r.server_mac, got.server_mac);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [47:0] srv, mac;
    logic [7:0] junk[$];
    int n, sel;
    own_mac_q = '0; host_tag_q = '0; phase_q = PhIdle; peer_q = '0;
    clear_parser();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_reg(RegOwnMac, 48'h0200_1234_5678);
    write_reg(RegHostTag, 48'h0000_0000_BEEF);

    // Directed: bad tag length, full exchange, short frame.
    srv = 48'h00AA_BBCC_DDEE;
    add_item(1'b0, 8'h00, 1'b0);
    add_disc_frame(own_mac_q, srv, 8'h07, 16'h0000, 2, 0);
    add_disc_frame(own_mac_q, srv, 8'h07, 16'h0000, 0, 1);
    add_frame('{8'hFF, 8'h00, 8'h65});
    add_disc_frame(48'hFFFF_FFFF_FFFF, 48'h0, 8'h65, 16'hFFFF, 3, 0);
    add_item(1'b1, 8'hFF, 1'b1);
    wait_drained();

    // Extremes of both registers, then random ones.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(RegOwnMac, 48'h0); write_reg(RegHostTag, 48'h0); end
        1: begin
          write_reg(RegOwnMac, 48'hFFFF_FFFF_FFFF);
          write_reg(RegHostTag, 48'h0000_0000_FFFF);
        end
        default: begin
          write_reg(RegOwnMac, 48'({$urandom, $urandom}));
          write_reg(RegHostTag, {32'd0, 16'($urandom)});
        end
      endcase
      add_item(1'b0, 8'($urandom), 1'($urandom));
      n = 0;
      while (n < 10) begin
        sel = $urandom_range(0, 9);
        mac = 48'({$urandom, $urandom});
        srv = 48'({$urandom, $urandom});
        if (sel == 0) begin
          add_item(1'b0, 8'($urandom), 1'($urandom));
          n++;
        end else if (sel <= 6) begin
          add_disc_frame(($urandom_range(0, 4) == 0) ? mac : own_mac_q, srv,
                         ($urandom_range(0, 1) ? CodePads : 8'h07), 16'($urandom),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                         $urandom_range(0, 2));
          n += 22;
        end else begin
          junk.delete();
          for (int k = $urandom_range(1, 24); k > 0; k--) junk.push_back(8'($urandom));
          add_frame(junk);
          n += junk.size();
        end
      end
      if (ph == 3) begin
        junk.delete();
        for (int k = 0; k < TbMaxFrame + 6; k++) junk.push_back(8'($urandom));
        add_frame(junk);
      end
      wait_drained();
    end
    $display("Accepted %0d items, checked %0d results (%0d frames, %0d sessions).",
             accepted, checked, frames_out, sessions);
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
